### rtl/core/trial_division_prime_test_macros.svh
// Assertion macros shared by the trial division prime test RTL.
// Each macro expects signals named clk and arst_n in the scope of use.
`ifndef TRIAL_DIVISION_PRIME_TEST_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define TDP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/tdp_pkg.sv
// ----------------------------------------------------------------------------
// tdp_pkg: shared definitions of the trial division prime test
// Default candidate width and the divider status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package tdp_pkg;

	// Default width of the candidate in bits.
	localparam int WIDTH_DEFAULT = 32;

	// Status of the shared divider as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

### rtl/core/tdp_channels.sv
// ----------------------------------------------------------------------------
// tdp_channels: valid/ready channels of the trial division prime test
// One channel carries candidates in, the other carries the verdicts out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdp_cand_if #(
	parameter int WIDTH = tdp_pkg::WIDTH_DEFAULT
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] candidate;

	modport source (output valid, output candidate, input ready);
	modport sink   (input valid, input candidate, output ready);
endinterface

interface tdp_res_if;
	logic valid;
	logic ready;
	logic is_prime;

	modport source (output valid, output is_prime, input ready);
	modport sink   (input valid, input is_prime, output ready);
endinterface

`default_nettype wire

### rtl/core/tdp_divider.sv
// ----------------------------------------------------------------------------
// tdp_divider: iterative restoring divider
// Produces quotient and remainder of two unsigned words, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tdp_divider #(
	parameter int WIDTH = tdp_pkg::WIDTH_DEFAULT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [WIDTH-1:0]   dividend,
	input  wire logic [WIDTH-1:0]   divisor,
	output logic      [WIDTH-1:0]   quotient,
	output logic      [WIDTH-1:0]   remainder,
	output tdp_pkg::div_stat_t      stat
);

	localparam int CNT_W = $clog2(WIDTH);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] den_q;

	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic             fits;

	// One restoring step: shift in the next dividend bit and try a subtract.
	always_comb begin
		trial = {rem_q, quo_q[WIDTH-1]};
		diff  = trial - {1'b0, den_q};
		fits  = !diff[WIDTH];
	end

	// Control: count the steps and flag the cycle after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WIDTH - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	// Datapath: the dividend shifts out as quotient bits shift in.
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
			quo_q <= {quo_q[WIDTH-2:0], fits};
		end
	end

	assign quotient    = quo_q;
	assign remainder   = rem_q;
	assign stat.busy   = busy_q;
	assign stat.done   = done_q;

endmodule

`default_nettype wire

### rtl/core/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test: primality test by 6k +/- 1 trial division
// A small sequencer drives one shared iterative divider over all divisors.
// ----------------------------------------------------------------------------
// Usage:
// Candidates arrive on the cand channel and one verdict per item leaves on
// the res channel (is_prime high for a prime). Both use valid/ready, and an
// item moves at a clock edge with valid and ready high.
// The block works on one candidate at a time; cand.ready is high only while
// the sequencer is idle. Zero to three and even values are decided without
// a division. Other candidates first take one division by three, then two
// divisions per loop step (divisors d and d+2, d = 5, 11, 17, ...) until d
// exceeds the quotient of the candidate by d, plus the division that finds
// this. Divisions run one at a time in the shared divider, so a prime n
// takes 2 + 2 * floor((floor(sqrt(n)) + 1) / 6) divisions. A verdict
// waits in the output register while res.ready is low; a new candidate is
// still taken then, and its verdict is held back until the older one has
// been taken. Reset clears the sequencer, the divider control and the
// output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "trial_division_prime_test_macros.svh"

module trial_division_prime_test #(
	parameter int WIDTH = tdp_pkg::WIDTH_DEFAULT
) (
	input wire logic     clk,
	input wire logic     arst_n,
	tdp_cand_if.sink     cand,
	tdp_res_if.source    res
);

	localparam logic [WIDTH-1:0] TWO     = WIDTH'(2);
	localparam logic [WIDTH-1:0] THREE   = WIDTH'(3);
	localparam logic [WIDTH-1:0] FOUR    = WIDTH'(4);
	localparam logic [WIDTH-1:0] FIVE    = WIDTH'(5);
	localparam logic [WIDTH-1:0] SIX     = WIDTH'(6);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_CHECK  = 6'b000010,
		ST_MOD3   = 6'b000100,
		ST_DIV_LO = 6'b001000,
		ST_DIV_HI = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t             state_q, state_d;
	logic [WIDTH-1:0]   n_q;
	logic [WIDTH-1:0]   d_q, d_d;
	logic               verdict_q, verdict_d;
	logic               res_valid_q;
	logic               res_bit_q;

	logic               div_start;
	logic [WIDTH-1:0]   div_divisor;
	logic [WIDTH-1:0]   div_quo;
	logic [WIDTH-1:0]   div_rem;
	tdp_pkg::div_stat_t div_stat;

	logic               cand_take;
	logic               res_load;

	tdp_divider #(
		.WIDTH (WIDTH)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (n_q),
		.divisor   (div_divisor),
		.quotient  (div_quo),
		.remainder (div_rem),
		.stat      (div_stat)
	);

	assign cand.ready = (state_q == ST_IDLE);
	assign cand_take  = cand.valid && cand.ready;
	assign res_load   = (state_q == ST_FINISH) && (!res_valid_q || res.ready);

	// Sequencer: trivial cases, the division by three, then the divisor loop.
	always_comb begin
		state_d     = state_q;
		d_d         = d_q;
		verdict_d   = verdict_q;
		div_start   = 1'b0;
		div_divisor = d_q;
		case (state_q)
			ST_IDLE: begin
				if (cand_take) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (n_q < TWO) begin
					verdict_d = 1'b0;
					state_d   = ST_FINISH;
				end else if (n_q < FOUR) begin
					verdict_d = 1'b1;
					state_d   = ST_FINISH;
				end else if (!n_q[0]) begin
					verdict_d = 1'b0;
					state_d   = ST_FINISH;
				end else begin
					div_start   = 1'b1;
					div_divisor = THREE;
					state_d     = ST_MOD3;
				end
			end
			ST_MOD3: begin
				if (div_stat.done) begin
					if (div_rem == '0) begin
						verdict_d = 1'b0;
						state_d   = ST_FINISH;
					end else begin
						d_d         = FIVE;
						div_start   = 1'b1;
						div_divisor = FIVE;
						state_d     = ST_DIV_LO;
					end
				end
			end
			ST_DIV_LO: begin
				// The quotient n/d gives the loop bound and the remainder the test.
				if (div_stat.done) begin
					if (d_q > div_quo) begin
						verdict_d = 1'b1;
						state_d   = ST_FINISH;
					end else if (div_rem == '0) begin
						verdict_d = 1'b0;
						state_d   = ST_FINISH;
					end else begin
						div_start   = 1'b1;
						div_divisor = d_q + TWO;
						state_d     = ST_DIV_HI;
					end
				end
			end
			ST_DIV_HI: begin
				if (div_stat.done) begin
					if (div_rem == '0) begin
						verdict_d = 1'b0;
						state_d   = ST_FINISH;
					end else begin
						d_d         = d_q + SIX;
						div_start   = 1'b1;
						div_divisor = d_q + SIX;
						state_d     = ST_DIV_LO;
					end
				end
			end
			ST_FINISH: begin
				if (res_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cand_take) begin
			n_q <= cand.candidate;
		end
		d_q       <= d_d;
		verdict_q <= verdict_d;
		if (res_load) begin
			res_bit_q <= verdict_d;
		end
	end

	assign res.valid    = res_valid_q;
	assign res.is_prime = res_bit_q;

	// Checks on the sequencer and its use of the divider.
	`TDP_ASSERT_IMPL(a_start_idle_div, div_start, !div_stat.busy)
	`TDP_ASSERT_IMPL(a_done_when_waiting, div_stat.done,
		(state_q == ST_MOD3) || (state_q == ST_DIV_LO) || (state_q == ST_DIV_HI))
	`TDP_ASSERT_NEXT(a_take_to_check, cand_take, state_q == ST_CHECK)
	`TDP_ASSERT_IMPL(a_divisor_odd, (state_q == ST_DIV_LO) || (state_q == ST_DIV_HI),
		d_q[0] && (d_q >= FIVE))
	`TDP_ASSERT_IMPL(a_load_no_overwrite, res_load, !res_valid_q || res.ready)

endmodule

`default_nettype wire

### bench/trial_division_prime_test_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test_test: self-checking bench of the prime test block
// Candidates on the cand channel are scored by an in-bench trial-division
// predictor or a typed probe verdict. Each verdict is checked against the
// oldest outstanding expectation while both channels idle and stall at random.
// ----------------------------------------------------------------------------

module trial_division_prime_test_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIDTH = tdp_pkg::WIDTH_DEFAULT;
	// Loop steps allowed for random candidates, which keeps most items short.
	localparam int unsigned STEP_BUDGET = 60;
	// Receiver hold-off at the start of the second phase, in cycles.
	localparam int unsigned LONG_HOLD = 20000;
	// Cycles without any accepted item before the run is abandoned.
	localparam int unsigned QUIET_LIMIT = 3000000;
	localparam int unsigned TAIL_CYCLES = 50;
	localparam int unsigned REPORT_CAP = 10;

	typedef struct packed {
		logic [WIDTH-1:0] value;
		logic             is_prime;
	} verdict_t;

	typedef struct packed {
		logic [WIDTH-1:0] value;
		logic             typed;
		logic             is_prime;
	} probe_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tdp_cand_if #(.WIDTH(WIDTH)) cand_ch ();
	tdp_res_if                   res_ch ();

	trial_division_prime_test #(.WIDTH(WIDTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cand   (cand_ch),
		.res    (res_ch)
	);

	// Expected verdicts in order of acceptance, and the one now on offer.
	verdict_t    verdict_q [$];
	verdict_t    offered;
	int unsigned bad_verdicts = 0;
	int unsigned quiet_cycles = 0;
	int unsigned src_idle_pct = 0;
	int unsigned sink_idle_pct = 0;
	int          phase = 0;

	// Fixed probes: the small cases, a few squares and products of primes,
	// and the values at the top of the range, including the largest prime.
	probe_row_t probes [24] = '{
		'{32'd0,          1'b1, 1'b0},
		'{32'd1,          1'b1, 1'b0},
		'{32'd2,          1'b1, 1'b1},
		'{32'd3,          1'b1, 1'b1},
		'{32'd4,          1'b1, 1'b0},
		'{32'd5,          1'b0, 1'b0},
		'{32'd7,          1'b0, 1'b0},
		'{32'd9,          1'b0, 1'b0},
		'{32'd25,         1'b0, 1'b0},
		'{32'd35,         1'b0, 1'b0},
		'{32'd49,         1'b0, 1'b0},
		'{32'd121,        1'b0, 1'b0},
		'{32'd143,        1'b0, 1'b0},
		'{32'd289,        1'b0, 1'b0},
		'{32'd323,        1'b0, 1'b0},
		'{32'd65521,      1'b0, 1'b0},
		'{32'd1022117,    1'b0, 1'b0},
		'{32'd16752649,   1'b0, 1'b0},
		'{32'h5555_5555,  1'b0, 1'b0},
		'{32'h8000_0001,  1'b0, 1'b0},
		'{32'hAAAA_AAAA,  1'b1, 1'b0},
		'{32'hFFFF_FFFB,  1'b1, 1'b1},
		'{32'hFFFF_FFFE,  1'b1, 1'b0},
		'{32'hFFFF_FFFF,  1'b1, 1'b0}
	};

	// Clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Trial division by 2, 3 and then 6k-1 / 6k+1 while d <= n / d, which
	// never wraps. Also returns how many loop steps were taken.
	function automatic bit primality_of(input logic [WIDTH-1:0] value,
			output int unsigned steps);
		longint unsigned n;
		longint unsigned d;
		n = value;
		steps = 0;
		if (n < 2) begin
			return 1'b0;
		end
		if (n < 4) begin
			return 1'b1;
		end
		if ((n % 2) == 0 || (n % 3) == 0) begin
			return 1'b0;
		end
		for (d = 5; d <= n / d; d += 6) begin
			steps++;
			if ((n % d) == 0 || (n % (d + 2)) == 0) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// Random candidate of random magnitude. Most are pushed onto 6k +/- 1 so
	// they reach the divisor loop; any that would loop too long are redrawn.
	function automatic logic [WIDTH-1:0] draw_candidate();
		logic [63:0]  v;
		int unsigned  bits;
		int unsigned  steps;
		while (1) begin
			bits = ($urandom_range(2, 0) == 0) ? WIDTH : $urandom_range(WIDTH - 1, 2);
			v = {$urandom, $urandom} & ((64'd1 << bits) - 64'd1);
			if ($urandom_range(99, 0) < 70) begin
				v = v - (v % 6) + ($urandom_range(1, 0) ? 64'd1 : 64'd5);
				if (v > ((64'd1 << WIDTH) - 64'd1)) begin
					v -= 64'd6;
				end
			end
			void'(primality_of(v[WIDTH-1:0], steps));
			if (steps <= STEP_BUDGET) begin
				return v[WIDTH-1:0];
			end
		end
	endfunction

	task automatic report_bad_verdict(input string what, input logic [WIDTH-1:0] value,
			input logic want, input logic got);
		bad_verdicts++;
		if (bad_verdicts <= REPORT_CAP) begin
			$display("%t %s: candidate %0d expected is_prime %0d got %0d",
				$realtime, what, value, want, got);
		end
	endtask

	// Offers one candidate, with random idle cycles first, and returns at the
	// edge where it is accepted.
	task automatic offer_candidate(input logic [WIDTH-1:0] value, input bit verdict);
		while ($urandom_range(99, 0) < src_idle_pct) begin
			cand_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cand_ch.valid <= 1'b1;
		cand_ch.candidate <= value;
		offered <= '{value, verdict};
		@(posedge clk);
		while (!cand_ch.ready) begin
			@(posedge clk);
		end
	endtask

	task automatic offer_random(input int unsigned count);
		logic [WIDTH-1:0] pick;
		int unsigned      steps;
		repeat (count) begin
			pick = draw_candidate();
			offer_candidate(pick, primality_of(pick, steps));
		end
	endtask

	// Sender goes quiet until every expected verdict has been taken.
	task automatic wait_for_verdicts();
		cand_ch.valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (verdict_q.size() != 0);
	endtask

	// Verdict checking, expectation bookkeeping and the quiet-cycle count.
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (verdict_q.size() == 0) begin
					report_bad_verdict("verdict with nothing outstanding", '0, 1'b0,
						res_ch.is_prime);
				end else begin
					want = verdict_q.pop_front();
					if (res_ch.is_prime !== want.is_prime) begin
						report_bad_verdict("wrong verdict", want.value, want.is_prime,
							res_ch.is_prime);
					end
				end
			end
			if (cand_ch.valid && cand_ch.ready) begin
				verdict_q = {verdict_q, offered};
			end
			if ((cand_ch.valid && cand_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Receiver: random stalls, and one long hold-off as the second phase opens
	// so that a verdict backs up and the input stalls behind it.
	initial begin : verdict_taker
		bit long_hold_done;
		long_hold_done = 1'b0;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (phase == 2 && !long_hold_done) begin
				long_hold_done = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else begin
				res_ch.ready <= ($urandom_range(99, 0) >= sink_idle_pct);
			end
		end
	end

	// Watchdog on cycles in which neither channel moves an item.
	initial begin : watchdog
		@(posedge arst_n);
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
		end
		$display("Mismatches found");
		$finish;
	end

	// Main sequence: reset, fixed probes, then three random phases.
	initial begin : stimulus
		int unsigned steps;
		bit          verdict;
		cand_ch.valid <= 1'b0;
		cand_ch.candidate <= '0;
		offered <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender idles lightly, receiver heavily.
		phase = 1;
		src_idle_pct = 15;
		sink_idle_pct = 45;
		foreach (probes[k]) begin
			verdict = probes[k].typed ? probes[k].is_prime
				: primality_of(probes[k].value, steps);
			offer_candidate(probes[k].value, verdict);
		end
		offer_random(26);
		wait_for_verdicts();

		// Roles swapped; the receiver opens with its long hold-off.
		phase = 2;
		src_idle_pct = 45;
		sink_idle_pct = 15;
		offer_random(25);
		wait_for_verdicts();

		// Back to back on both sides.
		phase = 3;
		src_idle_pct = 0;
		sink_idle_pct = 0;
		offer_random(25);
		wait_for_verdicts();
		repeat (TAIL_CYCLES) @(posedge clk);

		// Verdicts that never arrived count as mismatches.
		bad_verdicts += verdict_q.size();
		if (bad_verdicts == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
